FILE: design/tmdc_pkg.sv
// Shared types and constants of the triac motor direction controller.
`default_nettype none

package tmdc_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT_DIR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_BLINK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_BLINK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_ONE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TWO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE    = 3'd5;

  // Configuration reset values
  localparam logic        INIT_DIR_RST    = 1'b0;
  localparam logic [15:0] SLOW_BLINK_RST  = 16'd999;
  localparam logic [15:0] FAST_BLINK_RST  = 16'd1999;
  localparam logic [3:0]  PULSE_ONE_RST   = 4'd7;
  localparam logic [3:0]  PULSE_TWO_RST   = 4'd6;
  localparam logic [3:0]  PRESCALE_RST    = 4'd10;

  // Operating mode, from the two sensor bits {b, a}
  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_TOGGLE  = 2'd1,
    MODE_SET     = 2'd2,
    MODE_REVERSE = 2'd3
  } mode_e;

  // Speed select codes
  localparam logic [1:0] SPEED_OFF  = 2'd0;
  localparam logic [1:0] SPEED_LOW  = 2'd1;
  localparam logic [1:0] SPEED_MID  = 2'd2;
  localparam logic [1:0] SPEED_HIGH = 2'd3;

  // Drive levels
  localparam logic [1:0] LEVEL_NONE = 2'd0;
  localparam logic [1:0] LEVEL_ONE  = 2'd1;
  localparam logic [1:0] LEVEL_TWO  = 2'd2;

  // Gate register bits
  localparam logic [1:0] GATE_FWD = 2'b01;
  localparam logic [1:0] GATE_REV = 2'b10;

endpackage

`default_nettype wire

FILE: design/triac_motor_direction_ctrl.sv
// Top level of the triac motor direction controller.
`default_nettype none

// Each request on the input channel is one timer tick carrying the zero-cross flag, the sensor
// and speed pin samples and the two raw switch samples; each tick produces exactly one result
// holding the gate drives, the LED level, the current direction and a one-tick save request.
// A tick is captured in an input register, then counter and compare logic updates the controller
// state and loads the result register; a new tick is taken every cycle as long as results are
// drained. After reset the control step first runs on tick number (prescale_limit+1)^3; releasing
// a switch holds it off again until the last prescaler stage next wraps. Configuration registers
// are written through the plain write port while no tick is in flight; writing initial_direction
// also loads the direction.
module triac_motor_direction_ctrl
  import tmdc_pkg::*;
#(
  parameter int unsigned DEBOUNCE_SAMPLES = 5,
  parameter int unsigned BLINK_WIDTH      = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // configuration write port
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata_i,
  // tick request channel
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire                   zero_cross_i,
  input  wire                   sensor_a_active_i,
  input  wire                   sensor_b_active_i,
  input  wire [1:0]             speed_select_i,
  input  wire                   switch_a_pressed_i,
  input  wire                   switch_b_pressed_i,
  // result channel
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic                  gate_forward_o,
  output logic                  gate_reverse_o,
  output logic                  led_on_o,
  output logic                  direction_o,
  output logic                  save_strobe_o
);

  // Compare width for the blink counter against the 16-bit periods
  localparam int unsigned CMP_W = (BLINK_WIDTH > 16) ? BLINK_WIDTH : 16;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] slow_blink_q, fast_blink_q;
  logic [3:0]  pulse_one_q, pulse_two_q, prescale_lim_q;

  // ---------------------------------------------------------------------------
  // Pipeline control: input register feeds the step, step loads the result
  // ---------------------------------------------------------------------------
  logic in_valid_q, out_valid_q;
  logic step_fire;   // tick in the input register is processed this cycle
  logic in_take;     // input channel handshake

  assign step_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_fire;
  assign in_take    = in_valid_i && in_ready_o;

  // Input register payload
  logic       zc_in_q, sens_a_q, sens_b_q, sw_a_q, sw_b_q;
  logic [1:0] speed_in_q;

  // ---------------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------------
  logic [3:0]                  pulse_q, pulse_d;
  logic [BLINK_WIDTH-1:0]      blink_q, blink_d;
  logic [3:0]                  ps0_q, ps0_d, ps1_q, ps1_d, ps2_q, ps2_d;
  logic                        hold_q, hold_d;
  logic                        zc_seen_q, zc_seen_d;
  logic                        dir_q, dir_d;
  logic                        motor_q, motor_d;
  logic [1:0]                  speed_q, speed_d;
  logic                        led_q, led_d;
  logic [DEBOUNCE_SAMPLES-1:0] hist_a_q, hist_a_d, hist_b_q, hist_b_d;
  logic                        rel_a_q, rel_a_d, rel_b_q, rel_b_d;
  logic [1:0]                  gate_q, gate_d;
  logic [1:0]                  drive_q, drive_d;
  logic                        save_d;

  // Step temporaries
  logic [4:0]                  ps0_inc, ps1_inc, ps2_inc;
  logic                        wrap0, wrap1, wrap2;
  logic [DEBOUNCE_SAMPLES:0]   shift_a, shift_b;
  logic [DEBOUNCE_SAMPLES-1:0] hist_a_new, hist_b_new;
  logic                        released_a, released_b;
  logic [15:0]                 period;
  logic                        blink_on;
  mode_e                       mode;

  // Debounce windows: shift the new sample in, drop the oldest
  assign shift_a    = {hist_a_q, sw_a_q};
  assign shift_b    = {hist_b_q, sw_b_q};
  assign hist_a_new = shift_a[DEBOUNCE_SAMPLES-1:0];
  assign hist_b_new = shift_b[DEBOUNCE_SAMPLES-1:0];
  assign released_a = (hist_a_new == '0);
  assign released_b = (hist_b_new == '0);

  assign mode = mode_e'({sens_b_q, sens_a_q});

  // Prescaler chain: each stage wraps once it exceeds the limit and carries on
  assign ps0_inc = {1'b0, ps0_q} + 5'd1;
  assign wrap0   = ps0_inc > {1'b0, prescale_lim_q};
  assign ps1_inc = {1'b0, ps1_q} + {4'd0, wrap0};
  assign wrap1   = ps1_inc > {1'b0, prescale_lim_q};
  assign ps2_inc = {1'b0, ps2_q} + {4'd0, wrap1};
  assign wrap2   = ps2_inc > {1'b0, prescale_lim_q};

  always_comb begin
    // free-running part of the tick
    pulse_d   = (pulse_q != 4'd0) ? pulse_q - 4'd1 : pulse_q;
    blink_d   = blink_q + {{(BLINK_WIDTH-1){1'b0}}, 1'b1};
    ps0_d     = wrap0 ? 4'd0 : ps0_inc[3:0];
    ps1_d     = wrap1 ? 4'd0 : ps1_inc[3:0];
    ps2_d     = wrap2 ? 4'd0 : ps2_inc[3:0];
    hold_d    = wrap2 ? 1'b0 : hold_q;
    zc_seen_d = zc_seen_q | zc_in_q;

    dir_d    = dir_q;
    motor_d  = motor_q;
    speed_d  = speed_q;
    led_d    = led_q;
    hist_a_d = hist_a_q;
    hist_b_d = hist_b_q;
    rel_a_d  = rel_a_q;
    rel_b_d  = rel_b_q;
    gate_d   = gate_q;
    drive_d  = drive_q;
    save_d   = 1'b0;
    period   = slow_blink_q;
    blink_on = 1'b0;

    if (!hold_d) begin
      // Level and LED follow the speed bits sampled on the last control step
      if (motor_q) begin
        case (speed_q)
          SPEED_LOW, SPEED_HIGH: begin
            drive_d  = LEVEL_ONE;
            period   = slow_blink_q;
            blink_on = 1'b1;
          end
          SPEED_MID: begin
            drive_d  = LEVEL_TWO;
            period   = fast_blink_q;
            blink_on = 1'b1;
          end
          default: begin
            drive_d = LEVEL_NONE;
            led_d   = 1'b1;
          end
        endcase
        if (blink_on && (CMP_W'(blink_d) > CMP_W'(period))) begin
          blink_d = '0;
          led_d   = ~led_q;
        end
      end else begin
        led_d = 1'b1;
      end

      speed_d = speed_in_q;

      case (mode)
        MODE_TOGGLE: begin
          motor_d  = 1'b1;
          hist_a_d = hist_a_new;
          if (released_a != rel_a_q) begin
            rel_a_d = released_a;
            if (released_a) begin
              save_d = 1'b1;
              hold_d = 1'b1;
            end else begin
              dir_d = ~dir_q;
            end
          end
        end
        MODE_SET: begin
          motor_d  = 1'b1;
          hist_a_d = hist_a_new;
          hist_b_d = hist_b_new;
          if (released_a != rel_a_q) begin
            rel_a_d = released_a;
            if (released_a) begin
              save_d = 1'b1;
              hold_d = 1'b1;
            end else begin
              dir_d = 1'b0;
            end
          end
          // switch b wins when both are pressed in the same tick
          if (released_b != rel_b_q) begin
            rel_b_d = released_b;
            if (released_b) begin
              save_d = 1'b1;
              hold_d = 1'b1;
            end else begin
              dir_d = 1'b1;
            end
          end
        end
        MODE_REVERSE: begin
          dir_d   = 1'b0;
          motor_d = 1'b1;
        end
        default: begin
          drive_d = LEVEL_NONE;
          motor_d = 1'b0;
        end
      endcase

      // Serve a latched zero cross: load the pulse for the current level
      if (zc_seen_d) begin
        zc_seen_d = 1'b0;
        case (drive_d)
          LEVEL_ONE: pulse_d = pulse_one_q;
          LEVEL_TWO: pulse_d = pulse_two_q;
          default:   pulse_d = 4'd0;
        endcase
      end

      // Gate bits only accumulate while the pulse runs
      if (pulse_d != 4'd0) begin
        gate_d = gate_q | (dir_d ? GATE_FWD : GATE_REV);
      end else begin
        gate_d = 2'b00;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Control and state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      slow_blink_q   <= SLOW_BLINK_RST;
      fast_blink_q   <= FAST_BLINK_RST;
      pulse_one_q    <= PULSE_ONE_RST;
      pulse_two_q    <= PULSE_TWO_RST;
      prescale_lim_q <= PRESCALE_RST;
      pulse_q        <= 4'd0;
      blink_q        <= '0;
      ps0_q          <= 4'd0;
      ps1_q          <= 4'd0;
      ps2_q          <= 4'd0;
      hold_q         <= 1'b1;
      zc_seen_q      <= 1'b0;
      dir_q          <= INIT_DIR_RST;
      motor_q        <= 1'b0;
      speed_q        <= SPEED_OFF;
      led_q          <= 1'b1;
      hist_a_q       <= '0;
      hist_b_q       <= '0;
      rel_a_q        <= 1'b1;
      rel_b_q        <= 1'b1;
      gate_q         <= 2'b00;
      drive_q        <= LEVEL_NONE;
    end else begin
      // advance the two-stage handshake
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (step_fire) begin
        pulse_q   <= pulse_d;
        blink_q   <= blink_d;
        ps0_q     <= ps0_d;
        ps1_q     <= ps1_d;
        ps2_q     <= ps2_d;
        hold_q    <= hold_d;
        zc_seen_q <= zc_seen_d;
        dir_q     <= dir_d;
        motor_q   <= motor_d;
        speed_q   <= speed_d;
        led_q     <= led_d;
        hist_a_q  <= hist_a_d;
        hist_b_q  <= hist_b_d;
        rel_a_q   <= rel_a_d;
        rel_b_q   <= rel_b_d;
        gate_q    <= gate_d;
        drive_q   <= drive_d;
      end

      // The user must send configuration writes only while idle; the block does not enforce it.
      // An unknown index is dropped. The initial direction only matters at the moment it is written.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_INIT_DIR:   dir_q          <= cfg_wdata_i[0];
          REG_SLOW_BLINK: slow_blink_q   <= cfg_wdata_i;
          REG_FAST_BLINK: fast_blink_q   <= cfg_wdata_i;
          REG_PULSE_ONE:  pulse_one_q    <= cfg_wdata_i[3:0];
          REG_PULSE_TWO:  pulse_two_q    <= cfg_wdata_i[3:0];
          REG_PRESCALE:   prescale_lim_q <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers: input capture and result
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      zc_in_q    <= zero_cross_i;
      sens_a_q   <= sensor_a_active_i;
      sens_b_q   <= sensor_b_active_i;
      speed_in_q <= speed_select_i;
      sw_a_q     <= switch_a_pressed_i;
      sw_b_q     <= switch_b_pressed_i;
    end
    if (step_fire) begin
      gate_forward_o <= gate_d[0];
      gate_reverse_o <= gate_d[1];
      led_on_o       <= led_d;
      direction_o    <= dir_d;
      save_strobe_o  <= save_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
